### design/mbdio_pkg.sv
// Package: access modes and address map constants for the digital I/O counter device.
`default_nettype none

package mbdio_pkg;

  typedef enum logic [2:0] {
    MODE_RD_COIL  = 3'd0,
    MODE_RD_DISC  = 3'd1,
    MODE_RD_HOLD  = 3'd2,
    MODE_RD_INPUT = 3'd3,
    MODE_WR_COIL  = 3'd4,
    MODE_WR_HOLD  = 3'd5,
    MODE_TOGGLE   = 3'd6
  } mode_t;

  localparam int          AddrWidth  = 16;
  localparam int          DataWidth  = 16;
  localparam logic [15:0] CoilDiBase = 16'h0020;
  localparam logic [15:0] PackedReg  = 16'h0020;
  localparam logic [15:0] ClearBase  = 16'h0200;

endpackage

`default_nettype wire

### design/modbus_digital_io_counter_device.sv
// Top level: register-mapped digital inputs with edge counters and relay outputs.
// A transaction is captured in the input register; its result (done, ok, read_data) is then
//   registered in the result register.
// Throughput: one transaction per cycle; busy stays low, one input and one result register.
// Reset (rst, synchronous): input levels, counters and relays clear to zero, no result pending.
// The result is shown for one cycle only; the receiver cannot stall it.
`default_nettype none

module modbus_digital_io_counter_device #(
  parameter int NUM_CHANNELS = 8,
  parameter int COUNT_WIDTH  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire mbdio_pkg::mode_t             mode,
  input  wire logic [mbdio_pkg::AddrWidth-1:0] address,
  input  wire logic [mbdio_pkg::DataWidth-1:0] write_data,
  input  wire logic                         coil_level,
  output logic                              done,
  output logic                              ok,
  output logic [mbdio_pkg::DataWidth-1:0]   read_data
);
  import mbdio_pkg::*;

  localparam int          IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [15:0] N1   = 16'(NUM_CHANNELS);
  localparam logic [15:0] N2   = 16'(2 * NUM_CHANNELS);
  localparam logic [15:0] N3   = 16'(3 * NUM_CHANNELS);
  localparam logic [15:0] DiEnd  = 16'(32'(CoilDiBase) + NUM_CHANNELS);
  localparam logic [15:0] ClrEnd = 16'(32'(ClearBase) + NUM_CHANNELS);

  // input register
  logic                 valid;
  mode_t                mode_q;
  logic [AddrWidth-1:0] addr_q;
  logic [DataWidth-1:0] wdata_q;
  logic                 level_q;

  // device state
  logic [NUM_CHANNELS-1:0] levels;
  logic [NUM_CHANNELS-1:0] relays;
  logic [COUNT_WIDTH-1:0]  counts [NUM_CHANNELS];

  logic [NUM_CHANNELS-1:0] levels_next;
  logic [NUM_CHANNELS-1:0] relays_next;
  logic [COUNT_WIDTH-1:0]  counts_next [NUM_CHANNELS];
  logic                    ok_next;
  logic [DataWidth-1:0]    data_next;

  logic [AddrWidth-1:0] di_off, clr_off, t1_off, t2_off;
  logic [IdxW-1:0]      idx, di_idx, clr_idx, t1_idx, t2_idx;
  logic                 lo_hit, di_hit, clr_hit, t1_hit, t2_hit, pk_hit;
  logic [COUNT_WIDTH-1:0] cnt_rd;
  logic [DataWidth-1:0]   cnt16;

  assign busy = 1'b0;

  always_comb begin
    di_off  = addr_q - CoilDiBase;
    clr_off = addr_q - ClearBase;
    t1_off  = addr_q - N1;
    t2_off  = addr_q - N2;
    idx     = addr_q[IdxW-1:0];
    di_idx  = di_off[IdxW-1:0];
    clr_idx = clr_off[IdxW-1:0];
    t1_idx  = t1_off[IdxW-1:0];
    t2_idx  = t2_off[IdxW-1:0];
    lo_hit  = addr_q < N1;
    di_hit  = (addr_q >= CoilDiBase) && (addr_q < DiEnd);
    clr_hit = (addr_q >= ClearBase) && (addr_q < ClrEnd);
    t1_hit  = (addr_q >= N1) && (addr_q < N2);
    t2_hit  = (addr_q >= N2) && (addr_q < N3);
    pk_hit  = addr_q == PackedReg;
    cnt_rd  = counts[idx];
    cnt16   = DataWidth'(cnt_rd);
  end

  always_comb begin
    levels_next = levels;
    relays_next = relays;
    counts_next = counts;
    ok_next     = 1'b0;
    data_next   = '0;
    case (mode_q)
      MODE_RD_COIL: begin
        if (lo_hit) begin
          ok_next   = 1'b1;
          data_next = DataWidth'(relays[idx]);
        end else if (di_hit) begin
          ok_next   = 1'b1;
          data_next = DataWidth'(levels[di_idx]);
        end
      end
      MODE_RD_DISC: begin
        if (lo_hit) begin
          ok_next   = 1'b1;
          data_next = DataWidth'(levels[idx]);
        end
      end
      MODE_RD_HOLD, MODE_RD_INPUT: begin
        if (lo_hit) begin
          ok_next   = 1'b1;
          data_next = cnt16;
        end else if (pk_hit) begin
          ok_next   = 1'b1;
          data_next = (mode_q == MODE_RD_HOLD) ? DataWidth'(relays) : DataWidth'(levels);
        end
      end
      MODE_WR_COIL: begin
        if (lo_hit) begin
          ok_next          = 1'b1;
          relays_next[idx] = level_q;
        end else if (clr_hit) begin
          ok_next              = 1'b1;
          counts_next[clr_idx] = '0;
        end
      end
      MODE_WR_HOLD: begin
        if (pk_hit) begin
          ok_next     = 1'b1;
          relays_next = wdata_q[NUM_CHANNELS-1:0];
        end
      end
      MODE_TOGGLE: begin
        if (lo_hit) begin
          ok_next          = 1'b1;
          levels_next[idx] = ~levels[idx];
          if (!levels[idx]) begin
            counts_next[idx] = cnt_rd + 1'b1;
          end
        end else if (t1_hit) begin
          ok_next             = 1'b1;
          counts_next[t1_idx] = '0;
        end else if (t2_hit) begin
          ok_next             = 1'b1;
          relays_next[t2_idx] = ~relays[t2_idx];
        end
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mode_q  <= mode;
    addr_q  <= address;
    wdata_q <= write_data;
    level_q <= coil_level;
    if (rst) begin
      valid     <= 1'b0;
      done      <= 1'b0;
      ok        <= 1'b0;
      read_data <= '0;
      levels    <= '0;
      relays    <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        counts[i] <= '0;
      end
    end else begin
      valid     <= start && !busy;
      done      <= valid;
      ok        <= valid && ok_next;
      read_data <= valid ? data_next : '0;
      if (valid) begin
        levels <= levels_next;
        relays <= relays_next;
        counts <= counts_next;
      end
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (rst) valid |=> done)
    else $error("accepted transaction produced no result");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst) done |-> $past(valid))
    else $error("result without transaction");
  a_nok_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (read_data == '0))
    else $error("nonzero data on failed access");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !done |-> (!ok && (read_data == '0)))
    else $error("result ports active without strobe");
  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    (done && ($past(mode_q) == MODE_WR_COIL || $past(mode_q) == MODE_WR_HOLD ||
              $past(mode_q) == MODE_TOGGLE)) |-> (read_data == '0))
    else $error("write or toggle returned data");

endmodule

`default_nettype wire

### sim/modbus_digital_io_counter_device_tb.sv
// Testbench: directed and random register accesses checked against a predictor of the device.
`default_nettype none

module modbus_digital_io_counter_device_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbdio_pkg::*;

  localparam int          NumCh      = 8;
  localparam int          CycleLimit = 1_000_000;
  localparam logic [2:0]  ModeUndef  = 3'd7;

  typedef struct packed {
    logic        ok;
    logic [15:0] data;
  } access_reply_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  mode_t       mode;
  logic [15:0] address;
  logic [15:0] write_data;
  logic        coil_level;
  logic        done;
  logic        ok;
  logic [15:0] read_data;

  logic        in_level [NumCh];
  logic [15:0] event_count [NumCh];
  logic        relay_on [NumCh];

  access_reply_t expected_replies[$];
  int          idle_pct;
  int          cycle_count;
  int          fail_count;
  int          accepted_count;
  int          checked_count;
  int          ok_count;

  modbus_digital_io_counter_device u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .address    (address),
    .write_data (write_data),
    .coil_level (coil_level),
    .done       (done),
    .ok         (ok),
    .read_data  (read_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] pack_levels(input logic sel_relays);
    logic [15:0] v;
    v = '0;
    for (int i = 0; i < NumCh; i++) v[i] = sel_relays ? relay_on[i] : in_level[i];
    return v;
  endfunction

  // Applies one access to the predicted state and returns the reply it should produce.
  function automatic access_reply_t apply_access(input logic [2:0] acc_mode,
                                                 input logic [15:0] addr,
                                                 input logic [15:0] wdata,
                                                 input logic level);
    access_reply_t r;
    r = '0;
    case (acc_mode)
      MODE_RD_COIL: begin
        if (addr < NumCh) begin
          r.ok = 1'b1;
          r.data = 16'(relay_on[addr]);
        end else if (addr >= CoilDiBase && addr < CoilDiBase + NumCh) begin
          r.ok = 1'b1;
          r.data = 16'(in_level[addr - CoilDiBase]);
        end
      end
      MODE_RD_DISC: begin
        if (addr < NumCh) begin
          r.ok = 1'b1;
          r.data = 16'(in_level[addr]);
        end
      end
      MODE_RD_HOLD, MODE_RD_INPUT: begin
        if (addr < NumCh) begin
          r.ok = 1'b1;
          r.data = event_count[addr];
        end else if (addr == PackedReg) begin
          r.ok = 1'b1;
          r.data = pack_levels(acc_mode == MODE_RD_HOLD);
        end
      end
      MODE_WR_COIL: begin
        if (addr < NumCh) begin
          r.ok = 1'b1;
          relay_on[addr] = level;
        end else if (addr >= ClearBase && addr < ClearBase + NumCh) begin
          r.ok = 1'b1;
          event_count[addr - ClearBase] = '0;
        end
      end
      MODE_WR_HOLD: begin
        if (addr == PackedReg) begin
          r.ok = 1'b1;
          for (int i = 0; i < NumCh; i++) relay_on[i] = wdata[i];
        end
      end
      MODE_TOGGLE: begin
        if (addr < NumCh) begin
          r.ok = 1'b1;
          if (in_level[addr]) begin
            in_level[addr] = 1'b0;
          end else begin
            in_level[addr] = 1'b1;
            event_count[addr] = event_count[addr] + 16'd1;
          end
        end else if (addr < 2 * NumCh) begin
          r.ok = 1'b1;
          event_count[addr - NumCh] = '0;
        end else if (addr < 3 * NumCh) begin
          r.ok = 1'b1;
          relay_on[addr - 2 * NumCh] = ~relay_on[addr - 2 * NumCh];
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    access_reply_t exp_r;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else if (rst) begin
      for (int i = 0; i < NumCh; i++) begin
        in_level[i] = 1'b0;
        event_count[i] = '0;
        relay_on[i] = 1'b0;
      end
    end else begin
      if (done) begin
        if (expected_replies.size() == 0) begin
          $error("result with no transaction outstanding: ok=%0d read_data=%h", ok, read_data);
          fail_count++;
        end else begin
          exp_r = expected_replies.pop_front();
          checked_count++;
          if (ok !== exp_r.ok) begin
            $error("ok mismatch: expected %0d, actual %0d", exp_r.ok, ok);
            fail_count++;
          end
          if (read_data !== exp_r.data) begin
            $error("read_data mismatch: expected %h, actual %h", exp_r.data, read_data);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        exp_r = apply_access(mode, address, write_data, coil_level);
        expected_replies.push_back(exp_r);
        accepted_count++;
        if (exp_r.ok) ok_count++;
      end
    end
  end

  task automatic send_access(input logic [2:0] acc_mode, input logic [15:0] addr,
                             input logic [15:0] wdata = '0, input logic level = 1'b0);
    int gap;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start      <= 1'b1;
    mode       <= mode_t'(acc_mode);
    address    <= addr;
    write_data <= wdata;
    coil_level <= level;
    do @(posedge clk); while (busy);
  endtask

  task automatic test_reset_values();
    send_access(MODE_RD_HOLD, PackedReg);
    send_access(MODE_RD_INPUT, PackedReg);
    send_access(MODE_RD_HOLD, 16'd7);
  endtask

  task automatic test_coil_writes();
    send_access(MODE_WR_COIL, 16'd0, 16'hFFFF, 1'b1);
    send_access(MODE_WR_COIL, 16'd7, 16'h0000, 1'b1);
    send_access(MODE_RD_COIL, 16'd0);
    send_access(MODE_RD_COIL, 16'd7);
    send_access(MODE_RD_HOLD, PackedReg);
  endtask

  task automatic test_holding_write();
    // upper write_data bits must be ignored
    send_access(MODE_WR_HOLD, PackedReg, 16'hFF5A);
    send_access(MODE_RD_HOLD, PackedReg);
  endtask

  task automatic test_toggle_events();
    send_access(MODE_TOGGLE, 16'd0);
    send_access(MODE_TOGGLE, 16'd7);
    send_access(MODE_RD_DISC, 16'd0);
    send_access(MODE_RD_COIL, CoilDiBase + 16'd7);
    send_access(MODE_RD_INPUT, 16'd0);
    send_access(MODE_RD_INPUT, PackedReg);
    send_access(MODE_TOGGLE, 16'd8);
    send_access(MODE_TOGGLE, 16'd23);
    send_access(MODE_WR_COIL, ClearBase + 16'd7, 16'h0, 1'b1);
    send_access(MODE_RD_HOLD, 16'd0);
    send_access(MODE_RD_INPUT, 16'd7);
  endtask

  task automatic test_unmapped();
    send_access(MODE_RD_COIL, 16'd8);
    send_access(MODE_RD_COIL, CoilDiBase + 16'd8);
    send_access(MODE_RD_DISC, 16'd8);
    send_access(MODE_RD_HOLD, PackedReg + 16'd1);
    send_access(MODE_WR_COIL, ClearBase + 16'd8, 16'h0, 1'b1);
    send_access(MODE_WR_HOLD, PackedReg - 16'd1, 16'hFFFF);
    send_access(MODE_TOGGLE, 16'd24);
    send_access(MODE_TOGGLE, 16'hFFFF);
    send_access(ModeUndef, 16'd0, 16'hFFFF, 1'b1);
    send_access(MODE_RD_INPUT, 16'hFFFF);
  endtask

  task automatic test_counter_counts();
    // channel 3: clear, count rising edges from repeated toggles, one more, then clear by coil write
    send_access(MODE_TOGGLE, 16'd11);
    repeat (32) send_access(MODE_TOGGLE, 16'd3);
    send_access(MODE_RD_HOLD, 16'd3);
    send_access(MODE_TOGGLE, 16'd3);
    send_access(MODE_RD_INPUT, 16'd3);
    send_access(MODE_WR_COIL, ClearBase + 16'd3, 16'h0, 1'b0);
    send_access(MODE_RD_HOLD, 16'd3);
  endtask

  function automatic logic [15:0] pick_address();
    case ($urandom_range(9))
      0, 1, 2: return 16'($urandom_range(0, NumCh - 1));
      3:       return 16'($urandom_range(NumCh, 3 * NumCh - 1));
      4:       return CoilDiBase + 16'($urandom_range(0, NumCh - 1));
      5:       return PackedReg;
      6:       return ClearBase + 16'($urandom_range(0, NumCh - 1));
      7: begin
        case ($urandom_range(4))
          0:       return CoilDiBase - 16'd1;
          1:       return CoilDiBase + 16'(NumCh);
          2:       return ClearBase - 16'd1;
          3:       return ClearBase + 16'(NumCh);
          default: return 16'(3 * NumCh);
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_random_traffic(input int count, input int pct);
    logic [2:0] m;
    idle_pct = pct;
    repeat (count) begin
      m = ($urandom_range(99) < 3) ? ModeUndef : 3'($urandom_range(0, 6));
      send_access(m, pick_address(), 16'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    mode        = MODE_RD_COIL;
    address     = '0;
    write_data  = '0;
    coil_level  = 1'b0;
    idle_pct    = 0;
    cycle_count = 0;
    fail_count  = 0;
    accepted_count = 0;
    checked_count  = 0;
    ok_count       = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_coil_writes();
    test_holding_write();
    test_toggle_events();
    test_unmapped();
    test_counter_counts();
    test_random_traffic(160, 0);
    test_random_traffic(160, 71);
    test_random_traffic(161, 6);

    @(negedge clk);
    start <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (expected_replies.size() != 0) begin
      $error("%0d transactions never returned a result", expected_replies.size());
      fail_count++;
    end

    $display("Covered %0d transactions (%0d mapped), %0d results checked, incl. edge counting",
             accepted_count, ok_count, checked_count);
    $display("Random traffic ran with sender idle at 0, 71 and 6 percent");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
